// File: hw/rtl/rlebp_pkg.sv
`default_nettype none

package rlebp_pkg;

  localparam int unsigned GroupPix = 16;
  localparam int unsigned PixBits = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned LineWidthW = 11;
  localparam int unsigned HeightW = 16;
  localparam int unsigned RunW = 6;

  localparam logic [1:0] COUNT_TAG = 2'b11;

  localparam logic [CfgIdxW-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [LineWidthW-1:0] LINE_WIDTH_RST = 11'd640;
  localparam logic [HeightW-1:0] IMAGE_HEIGHT_RST = 16'd480;

  typedef struct packed {
    logic load_count;
    logic load_run;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic ignore;
    logic is_count;
    logic run_zero;
    logic emit;
    logic done;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [15:0] plane_bit0;
    logic [15:0] plane_bit1;
    logic [15:0] plane_bit2;
    logic [15:0] plane_bit3;
    logic        line_end;
    logic        image_end;
    logic        last_of_input;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/rlebp_if.sv
`default_nettype none

interface rlebp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] enc_byte;

  modport source (output valid, output enc_byte, input ready);
  modport sink (input valid, input enc_byte, output ready);
endinterface

interface rlebp_planes_if;
  logic        valid;
  logic        ready;
  logic [15:0] plane_bit0;
  logic [15:0] plane_bit1;
  logic [15:0] plane_bit2;
  logic [15:0] plane_bit3;
  logic        line_end;
  logic        image_end;
  logic        last_of_input;

  modport source (
    output valid, output plane_bit0, output plane_bit1, output plane_bit2,
    output plane_bit3, output line_end, output image_end, output last_of_input,
    input ready
  );
  modport sink (
    input valid, input plane_bit0, input plane_bit1, input plane_bit2,
    input plane_bit3, input line_end, input image_end, input last_of_input,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/rlebp_dp.sv
`default_nettype none

module rlebp_dp #(
  parameter int unsigned MAX_LINE_PIXELS = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rlebp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [rlebp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic [7:0]                       in_byte_i,
  input  wire rlebp_pkg::cmd_t                  cmd_i,
  output rlebp_pkg::status_t                    sts_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output rlebp_pkg::result_t                    out_data_o
);

  localparam int unsigned PW = $clog2(MAX_LINE_PIXELS);
  localparam int unsigned WW = (PW + 1 > rlebp_pkg::LineWidthW) ? PW + 1
                                                                 : rlebp_pkg::LineWidthW;
  localparam logic [WW-1:0] MAXW = WW'(MAX_LINE_PIXELS);
  localparam logic [WW-1:0] GRPW = WW'(rlebp_pkg::GroupPix);
  localparam int unsigned RW = rlebp_pkg::RunW;

  logic [rlebp_pkg::LineWidthW-1:0] lw_q;
  logic [rlebp_pkg::HeightW-1:0]    ih_q;
  logic                             pend_q;
  logic [RW-1:0]                    pcnt_q;
  logic [PW-1:0]                    pos_q, pos_d;
  logic [rlebp_pkg::HeightW-1:0]    line_q;
  logic [15:0][3:0]                 group_q, group_d;
  logic [RW-1:0]                    rem_q, rem_d;
  logic [3:0]                       pix_q;
  logic                             out_valid_q;
  rlebp_pkg::result_t               out_q, out_d;

  logic [WW-1:0] w, posw, to_line, grpw, remw, m, cntw, pos_sum;
  logic [3:0]    slot;
  logic [4:0]    cnt;
  logic [RW-1:0] rem_n;
  logic          line_hit, group_hit, emit, done, more_emit, last, img_end;
  logic [15:0]   planes [4];

  always_comb begin
    if (lw_q == '0) begin
      w = WW'(1);
    end else if (WW'(lw_q) > MAXW) begin
      w = MAXW;
    end else begin
      w = WW'(lw_q);
    end
    posw    = WW'(pos_q);
    slot    = 4'(pos_q);
    grpw    = GRPW - WW'(slot);
    to_line = (posw >= w) ? WW'(1) : w - posw;
    remw    = WW'(rem_q);
    m       = (remw < grpw) ? remw : grpw;
    cntw    = (m < to_line) ? m : to_line;
    cnt     = cntw[4:0];
    line_hit  = (cntw == to_line);
    group_hit = (cntw == grpw);
    emit      = line_hit || group_hit;
    rem_n     = rem_q - RW'(cnt);
    pos_sum   = posw + cntw;
    pos_d     = line_hit ? '0 : pos_sum[PW-1:0];
    done      = line_hit || (rem_n == '0);
    more_emit = (rem_n >= RW'(rlebp_pkg::GroupPix)) || ((w - pos_sum) <= WW'(rem_n));
    last      = done || !more_emit;
    img_end   = line_hit && (({1'b0, line_q} + 17'd1) >= {1'b0, ih_q});
    rem_d     = rem_n;
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if ((5'(i) >= {1'b0, slot}) && (6'(i) < (6'(slot) + 6'(cnt)))) begin
        group_d[i] = pix_q;
      end else begin
        group_d[i] = group_q[i];
      end
    end
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < 16; i++) begin
        planes[b][i] = group_d[i][b];
      end
    end
  end

  always_comb begin
    out_d.plane_bit0    = planes[0];
    out_d.plane_bit1    = planes[1];
    out_d.plane_bit2    = planes[2];
    out_d.plane_bit3    = planes[3];
    out_d.line_end      = line_hit;
    out_d.image_end     = img_end;
    out_d.last_of_input = last;
  end

  always_comb begin
    sts_o.ignore   = (line_q >= ih_q);
    sts_o.is_count = !pend_q && (in_byte_i[7:6] == rlebp_pkg::COUNT_TAG);
    sts_o.run_zero = pend_q && (pcnt_q == '0);
    sts_o.emit     = emit;
    sts_o.done     = done;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q        <= rlebp_pkg::LINE_WIDTH_RST;
      ih_q        <= rlebp_pkg::IMAGE_HEIGHT_RST;
      pend_q      <= 1'b0;
      pcnt_q      <= '0;
      pos_q       <= '0;
      line_q      <= '0;
      group_q     <= '0;
      rem_q       <= '0;
      pix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rlebp_pkg::CFG_LINE_WIDTH:   lw_q <= cfg_data_i[rlebp_pkg::LineWidthW-1:0];
          rlebp_pkg::CFG_IMAGE_HEIGHT: ih_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load_count) begin
        pend_q <= 1'b1;
        pcnt_q <= in_byte_i[RW-1:0];
      end
      if (cmd_i.load_run) begin
        pend_q <= 1'b0;
        pcnt_q <= '0;
        rem_q  <= pend_q ? pcnt_q : RW'(1);
        pix_q  <= in_byte_i[rlebp_pkg::PixBits-1:0];
      end
      if (cmd_i.step) begin
        rem_q   <= rem_d;
        pos_q   <= pos_d;
        group_q <= emit ? '0 : group_d;
        if (line_hit) begin
          line_q <= line_q + 16'd1;
        end
      end
      if (cmd_i.step && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/rlebp_ctrl.sv
`default_nettype none

module rlebp_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rlebp_pkg::status_t sts_i,
  output rlebp_pkg::cmd_t         cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic accept;

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.load_count = 1'b0;
    cmd_o.load_run   = 1'b0;
    cmd_o.step       = 1'b0;
    accept           = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i && !sts_i.ignore;
        if (accept && sts_i.is_count) begin
          cmd_o.load_count = 1'b1;
        end else if (accept) begin
          cmd_o.load_run = 1'b1;
          if (!sts_i.run_zero) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd_o.step = !sts_i.emit || sts_i.out_free;
        if (cmd_o.step && sts_i.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rle_image_to_bit_planes.sv
`default_nettype none

// channel | dir | payload                                   | accepted when
// in_if   | in  | enc_byte                                  | valid && ready
// out_if  | out | plane_bit0..3, line_end, image_end, last   | valid && ready
// cfg     | in  | cfg_idx_i, cfg_data_i                     | cfg_we_i
//
// a byte is taken while idle; a pixel byte is then written out stretch by
// stretch, each bounded by group end, line end or run end, and no new byte
// is taken until its run is done (one group per cycle unless output stalls)
// reset clears all counters and the open group; no clearing pass
// a stalled output holds the datapath only when a new group must be emitted

module rle_image_to_bit_planes #(
  parameter int unsigned MAX_LINE_PIXELS = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rlebp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rlebp_pkg::CfgDataW-1:0] cfg_data_i,
  rlebp_byte_if.sink                          in_if,
  rlebp_planes_if.source                      out_if
);

  rlebp_pkg::cmd_t    cmd;
  rlebp_pkg::status_t sts;
  rlebp_pkg::result_t res;

  rlebp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rlebp_dp #(
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (in_if.enc_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_data_o  (res)
  );

  assign out_if.plane_bit0    = res.plane_bit0;
  assign out_if.plane_bit1    = res.plane_bit1;
  assign out_if.plane_bit2    = res.plane_bit2;
  assign out_if.plane_bit3    = res.plane_bit3;
  assign out_if.line_end      = res.line_end;
  assign out_if.image_end     = res.image_end;
  assign out_if.last_of_input = res.last_of_input;

endmodule

`default_nettype wire
